// ----- rtl/circular_deque_assert.svh -----
// Assertion macros for the circular deque.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("circular_deque check failed");

// Next-cycle implication, checked outside reset.
`define CD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("circular_deque check failed");

`endif

// ----- rtl/cd_pkg.sv -----
package cd_pkg;

    localparam int DEPTH  = 8;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_REAR   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_ALL   = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        BK_IDLE  = 1'b0,
        BK_RDATA = 1'b1
    } t_bk_state;

    typedef struct packed {
        t_op                      op;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic             is_empty;
        logic [PTR_W-1:0] front;
        logic [PTR_W-1:0] rear;
    } t_back_stat;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        next_pos = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] prev_pos(input logic [PTR_W-1:0] p);
        prev_pos = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

// ----- rtl/cd_front.sv -----
module cd_front
    import cd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic signed [WORD_W-1:0] i_s_axis_tdata,  // [31:0] value_in
    input  logic [OP_W-1:0]          i_s_axis_tuser,  // [2:0] op
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd,
    input  logic                     i_cmd_ready
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    logic accept;
    logic op_known;

    assign o_s_axis_tready = !r_valid || i_cmd_ready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign op_known        = (i_s_axis_tuser <= OP_READ_ALL);

    // unused op codes are dropped here
    always_comb begin
        if (accept) begin
            n_valid = op_known;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op    <= t_op'(i_s_axis_tuser);
            r_cmd.value <= i_s_axis_tdata;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ----- rtl/cd_queue.sv -----
module cd_queue
    import cd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop_ready
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/cd_back.sv -----
module cd_back
    import cd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  t_cmd                     i_cmd,
    output logic                     o_cmd_ready,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic signed [WORD_W-1:0] o_m_axis_tdata,  // [31:0] value_out
    output logic [ST_W-1:0]          o_m_axis_tuser,  // [1:0] status
    output logic                     o_m_axis_tlast,
    output t_back_stat               o_stat
);

    t_bk_state r_state;
    t_bk_state n_state;

    logic [PTR_W-1:0] r_front;
    logic [PTR_W-1:0] r_rear;
    logic             r_empty;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_left;
    logic [PTR_W-1:0] n_front;
    logic [PTR_W-1:0] n_rear;
    logic             n_empty;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_left;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_value;
    t_status                  r_out_status;
    logic                     r_out_last;
    logic                     n_out_valid;
    logic                     load_out;
    logic signed [WORD_W-1:0] out_value;
    t_status                  out_status;
    logic                     out_last;

    logic signed [WORD_W-1:0] r_store [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;
    logic                     mem_we;
    logic                     mem_re;
    logic [PTR_W-1:0]         mem_waddr;
    logic [PTR_W-1:0]         mem_raddr;

    logic             slot_free;
    logic             take;
    logic             is_full;
    logic [CNT_W-1:0] live_m1;

    assign slot_free   = !r_out_valid || i_m_axis_tready;
    assign o_cmd_ready = (r_state == BK_IDLE) && slot_free;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign is_full     = !r_empty && (next_pos(r_rear) == r_front);

    // live count minus one
    always_comb begin
        if (r_rear >= r_front) begin
            live_m1 = CNT_W'(r_rear) - CNT_W'(r_front);
        end else begin
            live_m1 = CNT_W'(r_rear) + CNT_W'(DEPTH) - CNT_W'(r_front);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (take && !r_empty &&
                    (i_cmd.op == OP_POP_REAR || i_cmd.op == OP_POP_FRONT ||
                     i_cmd.op == OP_READ_ALL)) begin
                    n_state = BK_RDATA;
                end
            end
            BK_RDATA: begin
                if (slot_free && r_left == '0) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_front    = r_front;
        n_rear     = r_rear;
        n_empty    = r_empty;
        n_rd_ptr   = r_rd_ptr;
        n_left     = r_left;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_rear;
        mem_raddr  = r_front;
        load_out   = 1'b0;
        out_value  = '0;
        out_status = ST_OK;
        out_last   = 1'b1;
        case (r_state)
            BK_IDLE: begin
                if (take) begin
                    case (i_cmd.op)
                        OP_PUSH_REAR, OP_PUSH_FRONT: begin
                            load_out = 1'b1;
                            if (is_full) begin
                                out_status = ST_FULL;
                            end else if (r_empty) begin
                                n_front   = '0;
                                n_rear    = '0;
                                n_empty   = 1'b0;
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                            end else if (i_cmd.op == OP_PUSH_REAR) begin
                                n_rear    = next_pos(r_rear);
                                mem_we    = 1'b1;
                                mem_waddr = next_pos(r_rear);
                            end else begin
                                n_front   = prev_pos(r_front);
                                mem_we    = 1'b1;
                                mem_waddr = prev_pos(r_front);
                            end
                        end
                        OP_POP_REAR, OP_POP_FRONT: begin
                            if (r_empty) begin
                                load_out   = 1'b1;
                                out_status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = (i_cmd.op == OP_POP_REAR) ? r_rear : r_front;
                                n_left    = '0;
                                if (r_front == r_rear) begin
                                    n_empty = 1'b1;
                                    n_front = '0;
                                    n_rear  = '0;
                                end else if (i_cmd.op == OP_POP_REAR) begin
                                    n_rear = prev_pos(r_rear);
                                end else begin
                                    n_front = next_pos(r_front);
                                end
                            end
                        end
                        OP_READ_ALL: begin
                            if (r_empty) begin
                                load_out   = 1'b1;
                                out_status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_front;
                                n_rd_ptr  = next_pos(r_front);
                                n_left    = live_m1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_RDATA: begin
                if (slot_free) begin
                    load_out  = 1'b1;
                    out_value = r_rd_data;
                    out_last  = (r_left == '0);
                    if (r_left != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_rd_ptr;
                        n_rd_ptr  = next_pos(r_rd_ptr);
                        n_left    = r_left - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_rd_ptr    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_empty     <= n_empty;
            r_rd_ptr    <= n_rd_ptr;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value  <= out_value;
            r_out_status <= out_status;
            r_out_last   <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_store[mem_raddr];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    assign o_stat.busy     = (r_state != BK_IDLE);
    assign o_stat.is_empty = r_empty;
    assign o_stat.front    = r_front;
    assign o_stat.rear     = r_rear;

endmodule

// ----- rtl/circular_deque.sv -----
// Circular deque of 32-bit words, DEPTH entries.
// Input channel (s_axis): tuser carries op (0 push rear, 1 push front,
// 2 pop rear, 3 pop front, 4 read all), tdata carries the word to push.
// Unused op codes are accepted and dropped without a result.
// Output channel (m_axis): tdata is the popped or read word (zero unless
// status ok), tuser is status (0 ok, 1 full, 2 empty), tlast marks the
// final result of a transaction.
// A push or a refused pop or read reaches the output through the input
// register, the command queue and the output register; a pop or read that
// hits the store also passes through the registered store read.
// Throughput: pushes and refused ops one per cycle while results are taken;
// a pop or read-all keeps the back end busy, taking no commands, until its
// last result is loaded; a read-all streams one result per cycle on tready.
// A two-entry command queue sits between the input stage and the back end,
// so input transactions keep being taken while a result waits on tready.
// When the receiver stalls, the result holds in the output register and
// the back end stops; the input side stalls once the queue fills.
// Reset (synchronous, active low) empties the deque; no clearing pass.
`include "circular_deque_assert.svh"

module circular_deque
    import cd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic signed [WORD_W-1:0] i_s_axis_tdata,  // [31:0] value_in
    input  logic [OP_W-1:0]          i_s_axis_tuser,  // [2:0] op
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic signed [WORD_W-1:0] o_m_axis_tdata,  // [31:0] value_out
    output logic [ST_W-1:0]          o_m_axis_tuser,  // [1:0] status
    output logic                     o_m_axis_tlast
);

    logic       fr_valid;
    t_cmd       fr_cmd;
    logic       fr_ready;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       bk_ready;
    t_back_stat bk_stat;

    cd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (fr_valid),
        .o_cmd           (fr_cmd),
        .i_cmd_ready     (fr_ready)
    );

    cd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .i_push_cmd   (fr_cmd),
        .o_push_ready (fr_ready),
        .o_pop_valid  (q_valid),
        .o_pop_cmd    (q_cmd),
        .i_pop_ready  (bk_ready)
    );

    cd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_cmd_ready     (bk_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_stat          (bk_stat)
    );

    `CD_ASSERT_IMP(a_empty_ptrs, bk_stat.is_empty, bk_stat.front == '0 && bk_stat.rear == '0)
    `CD_ASSERT_IMP(a_refused_zero, o_m_axis_tvalid && o_m_axis_tuser != ST_OK, o_m_axis_tdata == '0 && o_m_axis_tlast)
    `CD_ASSERT_IMP(a_busy_no_take, bk_stat.busy, !bk_ready)
    `CD_ASSERT_NXT(a_hit_busy, q_valid && bk_ready && !bk_stat.is_empty && (q_cmd.op == OP_POP_REAR || q_cmd.op == OP_POP_FRONT || q_cmd.op == OP_READ_ALL), bk_stat.busy)

endmodule
